>>> sv/positional_ordered_list_engine_core_assert.svh
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_core assertion macros
// Shared assertion forms for the list engine checkers.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// checked only out of reset
`define POLE_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// checked at every edge, reset included
`define POLE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pole_pkg.sv
// ----------------------------------------------------------------------------
// pole_pkg
// Shared widths, request/status codes and control types of the list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pole_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STAT_W   = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(CAPACITY);

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // commit the request and load the result register
  } cmd_t;

endpackage

>>> sv/pole_ctrl.sv
// ----------------------------------------------------------------------------
// pole_ctrl
// Sequencer: accepts a word, runs it through the datapath, tracks result valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pole_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pole_pkg::cmd_t  cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, exec;

  assign accept = in_valid_i && (state_q == S_IDLE);
  // result register must be free, or be drained at this edge
  assign exec   = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = accept;
  assign cmd_o.exec    = exec;

endmodule

>>> sv/pole_datapath.sv
// ----------------------------------------------------------------------------
// pole_datapath
// Register cell per entry, shift network, parallel match and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pole_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pole_pkg::cmd_t                       cmd_i,
  input  logic                                 cfg_we_i,
  input  logic        [pole_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic        [pole_pkg::REQ_W-1:0]    req_type_i,
  input  logic        [pole_pkg::CNT_W-1:0]    position_i,
  input  logic signed [pole_pkg::DATA_W-1:0]   value_i,
  output logic        [pole_pkg::STAT_W-1:0]   status_o,
  output logic        [pole_pkg::IDX_W-1:0]    found_index_o,
  output logic        [pole_pkg::CNT_W-1:0]    entry_count_o
);

  logic [pole_pkg::CNT_W-1:0]  cap_q;
  logic [pole_pkg::CNT_W-1:0]  count_q, count_d;
  logic [pole_pkg::REQ_W-1:0]  req_q;
  logic [pole_pkg::CNT_W-1:0]  pos_q;
  logic [pole_pkg::DATA_W-1:0] val_q;
  logic [pole_pkg::DATA_W-1:0] store_q [pole_pkg::CAPACITY];

  logic [pole_pkg::CNT_W-1:0]  bound;
  logic                        ins_ok, rem_ok;
  logic [pole_pkg::STAT_W-1:0] status_d;
  logic [pole_pkg::IDX_W-1:0]  found_d;
  logic [pole_pkg::CAPACITY-1:0] match;
  logic                        hit;
  logic [pole_pkg::IDX_W-1:0]  hit_idx;

  logic [pole_pkg::STAT_W-1:0] status_q;
  logic [pole_pkg::IDX_W-1:0]  found_q;
  logic [pole_pkg::CNT_W-1:0]  count_out_q;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= pole_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  assign bound = (cap_q > pole_pkg::CAP_MAX) ? pole_pkg::CAP_MAX : cap_q;

  // parallel match over live entries, lowest index wins
  for (genvar g = 0; g < pole_pkg::CAPACITY; g++) begin : g_match
    localparam logic [pole_pkg::CNT_W-1:0] Idx = pole_pkg::CNT_W'(g);
    assign match[g] = (Idx < count_q) && (store_q[g] == val_q);
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = pole_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = pole_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_d = pole_pkg::ST_OK;
    found_d  = '0;
    count_d  = count_q;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    unique case (req_q)
      pole_pkg::REQ_INSERT: begin
        if (pos_q > count_q) begin
          status_d = pole_pkg::ST_BADPOS;
        end else if (count_q >= bound) begin
          status_d = pole_pkg::ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      pole_pkg::REQ_REMOVE: begin
        if (count_q == '0) begin
          status_d = pole_pkg::ST_EMPTY;
        end else if (pos_q >= count_q) begin
          status_d = pole_pkg::ST_BADPOS;
        end else begin
          rem_ok  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      pole_pkg::REQ_SEARCH: begin
        if (hit) begin
          found_d = hit_idx;
        end else begin
          status_d = pole_pkg::ST_NOTFOUND;
        end
      end
      pole_pkg::REQ_CLEAR: begin
        count_d = '0;
      end
      default: status_d = pole_pkg::ST_OK;
    endcase
  end

  // entry cells: hold, take left neighbor (insert), right neighbor (remove) or new word
  for (genvar g = 0; g < pole_pkg::CAPACITY; g++) begin : g_cell
    localparam logic [pole_pkg::CNT_W-1:0] Idx = pole_pkg::CNT_W'(g);
    logic [pole_pkg::DATA_W-1:0] left_w, right_w, cell_d;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = store_q[g-1];
    end
    if (g == pole_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = store_q[g+1];
    end

    always_comb begin
      cell_d = store_q[g];
      if (ins_ok) begin
        if (Idx == pos_q) begin
          cell_d = val_q;
        end else if (Idx > pos_q && Idx <= count_q) begin
          cell_d = left_w;
        end
      end else if (rem_ok) begin
        if (Idx >= pos_q && ({1'b0, Idx} + 1'b1) < {1'b0, count_q}) begin
          cell_d = right_w;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.exec) begin
        store_q[g] <= cell_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q    <= status_d;
      found_q     <= found_d;
      count_out_q <= count_d;
    end
  end

  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign entry_count_o = count_out_q;

endmodule

>>> sv/positional_ordered_list_engine_core.sv
// An ordered list of up to 16 signed 32-bit words held in one register cell
// per entry, with insert, remove, search and clear requests and one result
// word per request. A request's word is captured while the engine is idle;
// in the execute state the cell array then shifts or matches all entries
// at once and the result register loads; no new word is taken before that
// state ends. A stalled result holds the execute cycle until the result
// register drains. The user must write the capacity register with cfg_we_i
// only while the engine is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// positional_ordered_list_engine_core
// Top level: sequencer plus entry-cell datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_ordered_list_engine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [pole_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [pole_pkg::REQ_W-1:0]    req_type_i,
  input  logic        [pole_pkg::CNT_W-1:0]    position_i,
  input  logic signed [pole_pkg::DATA_W-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [pole_pkg::STAT_W-1:0]   status_o,
  output logic        [pole_pkg::IDX_W-1:0]    found_index_o,
  output logic        [pole_pkg::CNT_W-1:0]    entry_count_o
);

  pole_pkg::cmd_t cmd;

  pole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pole_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .entry_count_o (entry_count_o)
  );

endmodule

>>> sv/pole_chk.sv
// ----------------------------------------------------------------------------
// pole_chk
// Port-level checks on the list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_ordered_list_engine_core_assert.svh"

module pole_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [pole_pkg::STAT_W-1:0]        status_o,
  input logic [pole_pkg::IDX_W-1:0]         found_index_o,
  input logic [pole_pkg::CNT_W-1:0]         entry_count_o
);

  // valid is unknown until the first reset edge, so it is checked in the cycle after reset is seen low
  `POLE_ASSERT_ALWAYS(a_no_word_in_reset, clk_i,
                      !rst_ni |=> !out_valid_o, "result valid in reset")
  `POLE_ASSERT(a_count_bound, clk_i, rst_ni,
               out_valid_o |-> entry_count_o <= pole_pkg::CAP_MAX, "count above capacity")
  `POLE_ASSERT(a_status_code, clk_i, rst_ni,
               out_valid_o |-> status_o <= pole_pkg::ST_NOTFOUND, "unknown status")
  `POLE_ASSERT(a_index_only_ok, clk_i, rst_ni,
               (out_valid_o && status_o != pole_pkg::ST_OK) |-> found_index_o == '0,
               "index on failed request")
  `POLE_ASSERT(a_stall_hold, clk_i, rst_ni,
               (out_valid_o && out_stall_i) |=>
                 (out_valid_o && $stable(status_o) && $stable(entry_count_o)),
               "stalled result changed")

endmodule

bind positional_ordered_list_engine_core pole_chk u_pole_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .found_index_o (found_index_o),
  .entry_count_o (entry_count_o)
);
